// File: hdl/anbs_pkg.sv
// ----------------------------------------------------------------------------
// anbs_pkg
// Shared types and constants of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package anbs_pkg;

  localparam int NAL_LEN_W = 24;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  localparam logic [1:0] ZRUN_MAX  = 2'd3;
  localparam logic [1:0] ZRUN_LEAD = 2'd2;

  localparam logic STATUS_UNIT     = 1'b0;
  localparam logic STATUS_NO_START = 1'b1;

  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_UNIT = 2'd1,
    PH_BAD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic                 status;
    logic [NAL_LEN_W-1:0] nal_length;
    logic                 forbidden_zero;
    logic [1:0]           ref_idc;
    logic [5:0]           unit_type;
    logic                 end_of_buffer;
  } result_t;

endpackage

// File: hdl/anbs_in_if.sv
// ----------------------------------------------------------------------------
// anbs_in_if
// Byte stream channel: valid/ready handshake with one buffer byte.
// ----------------------------------------------------------------------------
interface anbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/anbs_out_if.sv
// ----------------------------------------------------------------------------
// anbs_out_if
// Result channel: valid/ready handshake with one NAL unit report.
// ----------------------------------------------------------------------------
interface anbs_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [23:0] nal_length;
  logic        forbidden_zero;
  logic [1:0]  ref_idc;
  logic [5:0]  unit_type;
  logic        end_of_buffer;

  modport source (
    output valid, output status, output nal_length, output forbidden_zero,
    output ref_idc, output unit_type, output end_of_buffer, input ready
  );
  modport sink (
    input valid, input status, input nal_length, input forbidden_zero,
    input ref_idc, input unit_type, input end_of_buffer, output ready
  );
endinterface

// File: hdl/annexb_nal_unit_splitter_unit.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_unit
// Splits an Annex B byte stream into NAL units and reports each unit.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, with last_byte on the final byte of a buffer,
// and gives one report per NAL unit: payload length without start codes
// (saturating) and the header fields decoded for H.264 or H.265 as set by
// cfg_wr_data. A buffer that does not open with a start code yields a single
// status 1 report at its last byte. Throughput is one byte per cycle while
// the result side keeps up; an accepted byte sits in the input register while
// the parse logic works on it, and its report is then loaded into the result
// register. A held report stalls the input side.
// Write the mode only while no buffer is in flight.
module annexb_nal_unit_splitter_unit #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  anbs_in_if.sink     in_chan,
  anbs_out_if.source  out_chan
);
  import anbs_pkg::*;

  logic    advance;
  logic    item_valid;
  item_t   item;
  logic    slot_free;
  logic    res_valid;
  result_t res;

  anbs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  anbs_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .slot_free   (slot_free),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  anbs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );
endmodule

// File: hdl/anbs_in_reg.sv
// ----------------------------------------------------------------------------
// anbs_in_reg
// Input register: captures one byte transaction and holds it until the
// parser advances.
// ----------------------------------------------------------------------------
module anbs_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  anbs_in_if.sink         in_chan,
  input  logic            advance,
  output logic            item_valid,
  output anbs_pkg::item_t item
);
  import anbs_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte <= in_chan.data_byte;
      item_r.last_byte <= in_chan.last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// File: hdl/anbs_parser.sv
// ----------------------------------------------------------------------------
// anbs_parser
// Start code tracker and unit counter: updates the parse state for one byte
// and forms the result that byte produces, if any.
// ----------------------------------------------------------------------------
module anbs_parser #(
  parameter int LENGTH_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              item_valid,
  input  anbs_pkg::item_t   item,
  input  logic              slot_free,
  output logic              advance,
  output logic              res_valid,
  output anbs_pkg::result_t res
);
  import anbs_pkg::*;

  localparam int LW = (LENGTH_BITS > NAL_LEN_W) ? LENGTH_BITS : NAL_LEN_W;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;
  localparam logic [NAL_LEN_W-1:0]   OUT_MAX = '1;

  logic                   codec_mode_r;
  phase_t                 phase_r, phase_nxt;
  logic [1:0]             zrun_r, zrun_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [7:0]             hdr_r, hdr_nxt;
  logic                   cap_r, cap_nxt;

  logic                   emit_unit, emit_err;
  logic [LENGTH_BITS-1:0] len;
  logic [7:0]             hdr_use;
  logic                   cap_use;
  logic [LW-1:0]          len_w;
  logic                   is_zero, is_one, last;

  assign advance = item_valid && slot_free;
  assign is_zero = (item.data_byte == BYTE_ZERO);
  assign is_one  = (item.data_byte == BYTE_ONE);
  assign last    = item.last_byte;

  always_comb begin
    phase_nxt = phase_r;
    zrun_nxt  = zrun_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    cap_nxt   = cap_r;
    emit_unit = 1'b0;
    emit_err  = 1'b0;
    len       = '0;
    hdr_use   = hdr_r;
    cap_use   = cap_r;

    unique case (phase_r)
      PH_LEAD: begin
        if (is_zero) begin
          if (zrun_r != ZRUN_MAX) begin
            zrun_nxt = zrun_r + 2'd1;
          end else begin
            phase_nxt = PH_BAD;
          end
        end else if (is_one && zrun_r >= ZRUN_LEAD) begin
          phase_nxt = PH_UNIT;
          zrun_nxt  = '0;
          cnt_nxt   = '0;
          hdr_nxt   = '0;
          cap_nxt   = 1'b0;
          // buffer ends right after the leading start code: empty unit
          emit_unit = last;
        end else begin
          phase_nxt = PH_BAD;
        end
        emit_err = last && !emit_unit;
      end
      PH_UNIT: begin
        if (is_one && zrun_r == ZRUN_MAX) begin
          // drop the three zeros of the start code unless saturated
          emit_unit = 1'b1;
          len       = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r - LENGTH_BITS'(3);
          zrun_nxt  = '0;
          cnt_nxt   = '0;
          hdr_nxt   = '0;
          cap_nxt   = 1'b0;
        end else begin
          cnt_nxt = (cnt_r != CNT_MAX) ? cnt_r + LENGTH_BITS'(1) : cnt_r;
          if (!cap_r) begin
            hdr_nxt = item.data_byte;
            cap_nxt = 1'b1;
          end
          hdr_use = hdr_nxt;
          cap_use = 1'b1;
          if (is_zero) begin
            zrun_nxt = (zrun_r != ZRUN_MAX) ? zrun_r + 2'd1 : zrun_r;
          end else begin
            zrun_nxt = '0;
          end
          emit_unit = last;
          len       = cnt_nxt;
        end
      end
      default: begin
        emit_err = last;
      end
    endcase

    // every buffer end starts over
    if (last) begin
      phase_nxt = PH_LEAD;
      zrun_nxt  = '0;
      cnt_nxt   = '0;
      hdr_nxt   = '0;
      cap_nxt   = 1'b0;
    end
  end

  assign len_w     = LW'(len);
  assign res_valid = emit_unit || emit_err;

  always_comb begin
    res = '0;
    if (emit_err) begin
      res.status        = STATUS_NO_START;
      res.end_of_buffer = 1'b1;
    end else begin
      res.status        = STATUS_UNIT;
      res.nal_length    = (len_w > LW'(OUT_MAX)) ? OUT_MAX : len_w[NAL_LEN_W-1:0];
      res.end_of_buffer = last;
      if (len != '0 && cap_use) begin
        res.forbidden_zero = hdr_use[7];
        if (codec_mode_r == CODEC_H265) begin
          res.unit_type = hdr_use[6:1];
        end else begin
          res.ref_idc   = hdr_use[6:5];
          res.unit_type = {1'b0, hdr_use[4:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= CODEC_H264;
      phase_r      <= PH_LEAD;
      zrun_r       <= '0;
      cnt_r        <= '0;
      hdr_r        <= '0;
      cap_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        codec_mode_r <= cfg_wr_data;
      end
      if (advance) begin
        phase_r <= phase_nxt;
        zrun_r  <= zrun_nxt;
        cnt_r   <= cnt_nxt;
        hdr_r   <= hdr_nxt;
        cap_r   <= cap_nxt;
      end
    end
  end
endmodule

// File: hdl/anbs_out_reg.sv
// ----------------------------------------------------------------------------
// anbs_out_reg
// Result register: holds one report until the result transaction completes.
// ----------------------------------------------------------------------------
module anbs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              res_valid,
  input  anbs_pkg::result_t res,
  output logic              slot_free,
  anbs_out_if.source        out_chan
);
  import anbs_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign slot_free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.status         = res_r.status;
  assign out_chan.nal_length     = res_r.nal_length;
  assign out_chan.forbidden_zero = res_r.forbidden_zero;
  assign out_chan.ref_idc        = res_r.ref_idc;
  assign out_chan.unit_type      = res_r.unit_type;
  assign out_chan.end_of_buffer  = res_r.end_of_buffer;
endmodule

// File: tb/tb_annexb_nal_unit_splitter_unit.sv
// ----------------------------------------------------------------------------
// tb_annexb_nal_unit_splitter_unit
// Self-checking bench for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
// Feeds byte buffers through the input channel with random gaps and random
// back-pressure on the report channel. A behavioral splitter inside the
// bench tracks the start code search, the unit byte count and the header
// byte, and queues the report each accepted byte should cause. Reports are
// compared field by field in order. Directed buffers cover the leading start
// code forms, unit splitting corner cases and header decode in both codec
// modes; random buffers follow, mostly well formed with some noise.
// Length saturation needs 2^24 bytes in one unit and is out of reach here.
module tb_annexb_nal_unit_splitter_unit;
  import anbs_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  anbs_in_if  in_chan();
  anbs_out_if out_chan();

  annexb_nal_unit_splitter_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Splitter state as seen by the bench
  logic                 codec_mode_q = CODEC_H264;
  phase_t               scan_phase   = PH_LEAD;
  logic [1:0]           zeros_seen   = '0;
  logic [NAL_LEN_W-1:0] unit_count   = '0;
  logic [7:0]           hdr_byte     = '0;
  logic                 hdr_valid    = 1'b0;

  result_t    pending_reports[$];
  logic [7:0] frame[$];
  int         mismatch_count = 0;
  bit         idle_en = 1'b1;

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias toward 00 and 01 so start codes show up inside payloads
  function automatic logic [7:0] pick_payload_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return BYTE_ZERO;
    if (r < 40) return BYTE_ONE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic result_t unit_report(logic [NAL_LEN_W-1:0] len, logic eob);
    result_t r;
    r = '0;
    r.status        = STATUS_UNIT;
    r.nal_length    = len;
    r.end_of_buffer = eob;
    if (len != 0 && hdr_valid) begin
      r.forbidden_zero = hdr_byte[7];
      if (codec_mode_q == CODEC_H265) begin
        r.unit_type = hdr_byte[6:1];
      end else begin
        r.ref_idc   = hdr_byte[6:5];
        r.unit_type = {1'b0, hdr_byte[4:0]};
      end
    end
    return r;
  endfunction

  function automatic result_t error_report();
    result_t r;
    r = '0;
    r.status        = STATUS_NO_START;
    r.end_of_buffer = 1'b1;
    return r;
  endfunction

  task automatic clear_unit();
    zeros_seen = '0;
    unit_count = '0;
    hdr_byte   = '0;
    hdr_valid  = 1'b0;
  endtask

  task automatic advance_splitter(input logic [7:0] b, input logic last);
    logic                 emitted;
    logic [NAL_LEN_W-1:0] len;
    emitted = 1'b0;
    case (scan_phase)
      PH_LEAD: begin
        if (b == BYTE_ZERO) begin
          if (zeros_seen != ZRUN_MAX) zeros_seen++;
          else scan_phase = PH_BAD;
        end else if (b == BYTE_ONE && zeros_seen >= ZRUN_LEAD) begin
          scan_phase = PH_UNIT;
          clear_unit();
          if (last) begin
            pending_reports.push_back(unit_report('0, 1'b1));
            emitted = 1'b1;
          end
        end else begin
          scan_phase = PH_BAD;
        end
        if (last && !emitted) pending_reports.push_back(error_report());
      end
      PH_UNIT: begin
        if (b == BYTE_ONE && zeros_seen == ZRUN_MAX) begin
          // a saturated count keeps its value; the start code is not taken off
          len = (unit_count == '1) ? unit_count : unit_count - NAL_LEN_W'(3);
          pending_reports.push_back(unit_report(len, last));
          clear_unit();
        end else begin
          if (unit_count != '1) unit_count++;
          if (!hdr_valid) begin
            hdr_byte  = b;
            hdr_valid = 1'b1;
          end
          if (b == BYTE_ZERO) begin
            if (zeros_seen != ZRUN_MAX) zeros_seen++;
          end else begin
            zeros_seen = '0;
          end
          if (last) pending_reports.push_back(unit_report(unit_count, 1'b1));
        end
      end
      default: begin
        if (last) pending_reports.push_back(error_report());
      end
    endcase
    if (last) begin
      scan_phase = PH_LEAD;
      clear_unit();
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    if (mismatch_count < 40)
      $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
    mismatch_count++;
  endtask

  task automatic check_report(input result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch("unexpected report, length", 0, got.nal_length);
      return;
    end
    want = pending_reports.pop_front();
    if (got.status != want.status)
      report_mismatch("status", want.status, got.status);
    if (got.nal_length != want.nal_length)
      report_mismatch("nal_length", want.nal_length, got.nal_length);
    if (got.forbidden_zero != want.forbidden_zero)
      report_mismatch("forbidden_zero", want.forbidden_zero, got.forbidden_zero);
    if (got.ref_idc != want.ref_idc)
      report_mismatch("ref_idc", want.ref_idc, got.ref_idc);
    if (got.unit_type != want.unit_type)
      report_mismatch("unit_type", want.unit_type, got.unit_type);
    if (got.end_of_buffer != want.end_of_buffer)
      report_mismatch("end_of_buffer", want.end_of_buffer, got.end_of_buffer);
  endtask

  // Report side: check each transaction, then pick the next ready level
  initial begin : report_sink
    int      stall_left;
    result_t got;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.status         = out_chan.status;
        got.nal_length     = out_chan.nal_length;
        got.forbidden_zero = out_chan.forbidden_zero;
        got.ref_idc        = out_chan.ref_idc;
        got.unit_type      = out_chan.unit_type;
        got.end_of_buffer  = out_chan.end_of_buffer;
        check_report(got);
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= last;
    do @(posedge clk); while (!in_chan.ready);
    advance_splitter(b, last);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    frame.delete();
  endtask

  // Hold input until all reports are back, let the pipe empty, then write
  task automatic set_codec(input logic mode);
    in_chan.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    codec_mode_q = mode;
  endtask

  task automatic test_leading_start_code();
    set_codec(CODEC_H264);
    frame = '{8'h00, 8'h00, 8'h01};        // ends right after the start code
    send_frame();
    frame = '{8'h00, 8'h00};               // ends inside the start code
    send_frame();
    frame = '{8'h47};                      // bad first byte, also the last
    send_frame();
    frame = '{8'h00, 8'h00, 8'h00, 8'h00}; // fourth zero breaks the lead
    send_frame();
  endtask

  task automatic test_unit_splitting();
    // 4-byte lead, header FF, extra zero kept in payload, empty unit,
    // trailing start code closing the buffer
    frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h01, 8'h00, 8'h00, 8'h00, 8'h01};
    send_frame();
  endtask

  task automatic test_header_decode();
    set_codec(CODEC_H265);
    frame = '{8'h00, 8'h00, 8'h01, 8'h7E, 8'h00};
    send_frame();
    frame = '{8'h00, 8'h00, 8'h01, 8'h81};
    send_frame();
    set_codec(CODEC_H264);
    frame = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h7F};
    send_frame();
  endtask

  task automatic build_good_frame();
    int units;
    int len;
    units = $urandom_range(1, 4);
    if ($urandom_range(0, 1)) frame.push_back(BYTE_ZERO);
    frame.push_back(BYTE_ZERO);
    frame.push_back(BYTE_ZERO);
    frame.push_back(BYTE_ONE);
    for (int u = 0; u < units; u++) begin
      if (u > 0) begin
        if ($urandom_range(0, 3) == 0) frame.push_back(BYTE_ZERO);
        frame.push_back(BYTE_ZERO);
        frame.push_back(BYTE_ZERO);
        frame.push_back(BYTE_ZERO);
        frame.push_back(BYTE_ONE);
      end
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      for (int i = 0; i < len; i++) frame.push_back(pick_payload_byte());
    end
    if ($urandom_range(0, 4) == 0) begin
      frame.push_back(BYTE_ZERO);
      frame.push_back(BYTE_ZERO);
      frame.push_back(BYTE_ZERO);
      frame.push_back(BYTE_ONE);
    end
  endtask

  task automatic build_noise_frame();
    int tail;
    tail = $urandom_range(0, 8);
    case ($urandom_range(0, 4))
      0: frame.push_back(8'($urandom_range(2, 255)));
      1: frame = '{8'h00, 8'h00, 8'($urandom_range(2, 255))};
      2: frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
      3: begin
        // truncated lead: the buffer stops in the zeros
        frame.push_back(BYTE_ZERO);
        if ($urandom_range(0, 1)) frame.push_back(BYTE_ZERO);
        tail = 0;
      end
      default: frame = '{8'h00, 8'h01};
    endcase
    for (int i = 0; i < tail; i++) frame.push_back(pick_payload_byte());
  endtask

  task automatic test_random_buffers(input int byte_budget);
    int sent;
    sent = 0;
    while (sent < byte_budget) begin
      if ($urandom_range(0, 99) < 80) begin
        build_good_frame();
      end else begin
        build_noise_frame();
      end
      sent += frame.size();
      send_frame();
    end
  endtask

  initial begin : stimulus
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= '0;
    in_chan.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_leading_start_code();
    test_unit_splitting();
    test_header_decode();

    set_codec(CODEC_H264);
    test_random_buffers(125);
    set_codec(CODEC_H265);
    idle_en = 1'b0;
    test_random_buffers(125);
    idle_en = 1'b1;
    set_codec(1'($urandom_range(0, 1)));
    test_random_buffers(125);
    set_codec(CODEC_H265);
    test_random_buffers(125);

    in_chan.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Far beyond the slowest legal run: every byte and report at its longest gap
  initial begin : watchdog
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
hdl/anbs_pkg.sv
hdl/anbs_in_if.sv
hdl/anbs_out_if.sv
hdl/anbs_in_reg.sv
hdl/anbs_parser.sv
hdl/anbs_out_reg.sv
hdl/annexb_nal_unit_splitter_unit.sv
tb/tb_annexb_nal_unit_splitter_unit.sv
